FILE: sv/des_pkg.sv
// Shared types, constants and codes for the deadline eviction selector.
package des_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int MAX_SCAN = 64;

  localparam int KEY_W = 64;
  localparam int TIME_W = 63;
  localparam int SUM_W = 64;
  localparam int SIZE_W = 32;
  localparam int ORDER_W = 32;
  localparam int SCORE_W = 31;
  localparam int WEIGHT_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IN_W = 240;
  localparam int OUT_W = 144;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [9:0] URG_BASE = 10'd1000;
  localparam logic [1:0] PRIO_CRIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_COLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_WARM = 1'd1;

  localparam logic [1:0] OP_REG = 2'd0;
  localparam logic [1:0] OP_UNREG = 2'd1;
  localparam logic [1:0] OP_EVICT = 2'd2;
  localparam logic [1:0] OP_COUNT = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_EXISTS = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_NONE = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SUM_W-1:0]   sum;
    logic [1:0]         prio;
    logic [SIZE_W-1:0]  size;
    logic [ORDER_W-1:0] order;
  } slot_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               vld;
    logic               evict;
    logic               match;
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [ORDER_W-1:0] order;
  } tag_t;

endpackage

FILE: sv/deadline_eviction_selector_core.sv
// Top level: deadline eviction selector with scan sequencer and result register.
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one operation per word:
// register, unregister, evict or count. Results leave on m_tvalid/m_tready/
// m_tdata with m_tlast marking the final result of an input word. The user
// must write weights through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this. Every operation but a
// rejected register or an evict with a zero limit walks all 64 slots through
// the slot memory read port and the shared three-stage score unit, one slot
// per cycle, then settles and loads the result register. An evict with limit
// n runs up to n scans, one result per scan. Rejected registers and zero-limit
// evicts skip the scan. s_tready is high only while idle; one word is handled
// at a time. A result waiting in the output register does not block accepting
// the next word; a stalled receiver holds further results and the scan.
// Reset (rst, synchronous) empties the table, zeroes the insertion counter,
// restores the default weights and drops any pending result. No clearing pass.
module deadline_eviction_selector_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // opcode, key, deadline slack, priority_req, block size, now_us, scan_limit
  input  logic [des_pkg::IN_W-1:0]          s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, evicted_key, evicted_size, evicted_score, tally
  output logic [des_pkg::OUT_W-1:0]         m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [des_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [des_pkg::WEIGHT_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t                          state;
  logic [des_pkg::WEIGHT_W-1:0]    weight_cold;
  logic [des_pkg::WEIGHT_W-1:0]    weight_warm;
  logic [des_pkg::DEPTH-1:0]       valid;
  logic [des_pkg::ORDER_W-1:0]     next_order;

  logic [1:0]                      req_op;
  logic [des_pkg::KEY_W-1:0]       req_key;
  logic [des_pkg::SUM_W-1:0]       req_sum;
  logic [1:0]                      req_prio;
  logic [des_pkg::SIZE_W-1:0]      req_size;
  logic [des_pkg::TIME_W-1:0]      req_now;
  logic [des_pkg::CNT_W-1:0]       req_lim;

  logic [des_pkg::IDX_W:0]         issue;
  logic                            p1_valid;
  logic [des_pkg::IDX_W-1:0]       p1_idx;

  logic                            found;
  logic [des_pkg::IDX_W-1:0]       found_idx;
  logic                            free_found;
  logic [des_pkg::IDX_W-1:0]       free_idx;
  logic [des_pkg::CNT_W-1:0]       cnt;
  logic                            best_found;
  logic [des_pkg::IDX_W-1:0]       best_idx;
  logic [des_pkg::KEY_W-1:0]       best_key;
  logic [des_pkg::SIZE_W-1:0]      best_size;
  logic [des_pkg::SCORE_W-1:0]     top_score;
  logic [des_pkg::ORDER_W-1:0]     best_order;
  logic [des_pkg::CNT_W-1:0]       done;

  logic [2:0]                      res_status;
  logic [des_pkg::KEY_W-1:0]       res_key;
  logic [des_pkg::SIZE_W-1:0]      res_size;
  logic [des_pkg::SCORE_W-1:0]     res_score;
  logic [des_pkg::CNT_W-1:0]       res_tally;
  logic                            res_last;

  // input word fields
  logic [1:0]                      in_op;
  logic [des_pkg::KEY_W-1:0]       in_key;
  logic [des_pkg::TIME_W-1:0]      in_deadline;
  logic [2:0]                      in_prio;
  logic [des_pkg::SIZE_W-1:0]      in_size;
  logic [des_pkg::TIME_W-1:0]      in_now;
  logic [des_pkg::CNT_W-1:0]       in_scan;
  logic [des_pkg::CNT_W-1:0]       in_lim;
  logic                            in_bad;

  logic                            mem_we;
  des_pkg::slot_t                  mem_wdata;
  logic                            mem_re;
  des_pkg::slot_t                  mem_rdata;
  des_pkg::tag_t                   p1_tag;
  logic                            sc_valid;
  logic [des_pkg::SCORE_W-1:0]     sc_score;
  des_pkg::tag_t                   sc_tag;
  logic                            take;
  logic                            better;
  logic                            out_free;
  logic [des_pkg::CNT_W-1:0]       done_inc;

  assign in_op = s_tdata[1:0];
  assign in_key = s_tdata[65:2];
  assign in_deadline = s_tdata[128:66];
  assign in_prio = s_tdata[131:129];
  assign in_size = s_tdata[163:132];
  assign in_now = s_tdata[226:164];
  assign in_scan = s_tdata[233:227];
  assign in_lim = (in_scan > des_pkg::CNT_W'(des_pkg::MAX_SCAN)) ?
                  des_pkg::CNT_W'(des_pkg::MAX_SCAN) : in_scan;
  assign in_bad = (in_prio > {1'b0, des_pkg::PRIO_CRIT}) || (in_size == '0);

  assign s_tready = (state == S_IDLE);
  assign take = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done_inc = done + 1'b1;

  assign mem_re = (state == S_SCAN) && !issue[des_pkg::IDX_W];
  assign mem_we = (state == S_FINISH) && (req_op == des_pkg::OP_REG) && !found && free_found;
  assign mem_wdata = '{key: req_key, sum: req_sum, prio: req_prio, size: req_size,
                       order: next_order};

  des_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_idx),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (issue[des_pkg::IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    p1_tag.idx = p1_idx;
    p1_tag.vld = valid[p1_idx];
    p1_tag.evict = valid[p1_idx] && !mem_rdata.prio[1];
    p1_tag.match = valid[p1_idx] && (mem_rdata.key == req_key);
    p1_tag.key = mem_rdata.key;
    p1_tag.size = mem_rdata.size;
    p1_tag.order = mem_rdata.order;
  end

  des_score_unit u_score (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_sum    (mem_rdata.sum),
    .in_now    (req_now),
    .in_weight (mem_rdata.prio[0] ? weight_warm : weight_cold),
    .in_tag    (p1_tag),
    .out_valid (sc_valid),
    .out_score (sc_score),
    .out_tag   (sc_tag)
  );

  assign better = !best_found || (sc_score > top_score) ||
                  ((sc_score == top_score) && (sc_tag.order < best_order));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      weight_cold <= des_pkg::WEIGHT_W'(1000);
      weight_warm <= des_pkg::WEIGHT_W'(500);
      valid <= '0;
      next_order <= '0;
      issue <= '0;
      p1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == des_pkg::REG_WEIGHT_COLD) begin
        weight_cold <= cfg_data;
      end
      if (cfg_we && cfg_index == des_pkg::REG_WEIGHT_WARM) begin
        weight_warm <= cfg_data;
      end
      p1_valid <= mem_re;
      p1_idx <= issue[des_pkg::IDX_W-1:0];
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            req_op <= in_op;
            req_key <= in_key;
            req_sum <= {1'b0, in_deadline} + {1'b0, in_now};
            req_prio <= in_prio[1:0];
            req_size <= in_size;
            req_now <= in_now;
            req_lim <= in_lim;
            done <= '0;
            res_key <= '0;
            res_size <= '0;
            res_score <= '0;
            res_tally <= '0;
            res_last <= 1'b1;
            issue <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            cnt <= '0;
            if (in_op == des_pkg::OP_REG && in_bad) begin
              res_status <= des_pkg::ST_INVALID;
              state <= S_EMIT;
            end else if (in_op == des_pkg::OP_EVICT && in_lim == '0) begin
              res_status <= des_pkg::ST_NONE;
              state <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            issue <= issue + 1'b1;
          end
          if (sc_valid) begin
            if (sc_tag.match) begin
              found <= 1'b1;
              found_idx <= sc_tag.idx;
            end
            if (!sc_tag.vld && !free_found) begin
              free_found <= 1'b1;
              free_idx <= sc_tag.idx;
            end
            if (sc_tag.evict) begin
              cnt <= cnt + 1'b1;
              if (better) begin
                best_found <= 1'b1;
                best_idx <= sc_tag.idx;
                best_key <= sc_tag.key;
                best_size <= sc_tag.size;
                top_score <= sc_score;
                best_order <= sc_tag.order;
              end
            end
            if (sc_tag.idx == des_pkg::IDX_W'(des_pkg::DEPTH - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          res_key <= '0;
          res_size <= '0;
          res_score <= '0;
          res_tally <= '0;
          res_last <= 1'b1;
          state <= S_EMIT;
          case (req_op)
            des_pkg::OP_REG: begin
              if (found) begin
                res_status <= des_pkg::ST_EXISTS;
              end else if (!free_found) begin
                res_status <= des_pkg::ST_FULL;
              end else begin
                res_status <= des_pkg::ST_OK;
                valid[free_idx] <= 1'b1;
                next_order <= next_order + 1'b1;
              end
            end
            des_pkg::OP_UNREG: begin
              if (found) begin
                res_status <= des_pkg::ST_OK;
                valid[found_idx] <= 1'b0;
              end else begin
                res_status <= des_pkg::ST_NOTFOUND;
              end
            end
            des_pkg::OP_COUNT: begin
              res_status <= des_pkg::ST_OK;
              res_tally <= cnt;
            end
            default: begin
              if (best_found) begin
                valid[best_idx] <= 1'b0;
                res_status <= des_pkg::ST_OK;
                res_key <= best_key;
                res_size <= best_size;
                res_score <= top_score;
                res_tally <= done_inc;
                res_last <= (done_inc == req_lim) || (cnt == des_pkg::CNT_W'(1));
                done <= done_inc;
              end else begin
                res_status <= des_pkg::ST_NONE;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata <= {7'd0, res_tally, res_score, res_size, res_key, res_status};
            m_tlast <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              issue <= '0;
              found <= 1'b0;
              free_found <= 1'b0;
              best_found <= 1'b0;
              cnt <= '0;
              state <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_reg_free_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !valid[free_idx])
    else $error("register into an occupied slot");

  a_evict_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && req_op == des_pkg::OP_EVICT && best_found) |-> valid[best_idx])
    else $error("evict pick is not a live slot");

  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && req_op == des_pkg::OP_EVICT) |-> done < req_lim)
    else $error("evict scan past the limit");

endmodule

FILE: sv/des_slot_mem.sv
// Slot table storage: one write port, one registered read port.
module des_slot_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [des_pkg::IDX_W-1:0]  waddr,
  input  des_pkg::slot_t             wdata,
  input  logic                       re,
  input  logic [des_pkg::IDX_W-1:0]  raddr,
  output des_pkg::slot_t             rdata
);

  des_pkg::slot_t mem [des_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/des_score_unit.sv
// Three-stage pipelined score unit, shared by every slot of a scan.
module des_score_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [des_pkg::SUM_W-1:0]     in_sum,
  input  logic [des_pkg::TIME_W-1:0]    in_now,
  input  logic [des_pkg::WEIGHT_W-1:0]  in_weight,
  input  des_pkg::tag_t                 in_tag,
  output logic                          out_valid,
  output logic [des_pkg::SCORE_W-1:0]   out_score,
  output des_pkg::tag_t                 out_tag
);

  // |d|/10 = a*104857 + (6a + b)/10 with d = a*2^20 + b, d < 2^35
  localparam logic [16:0] RECIP_HI = 17'd104857;
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

  logic                          s1_valid;
  logic                          s1_neg;
  logic                          s1_big;
  logic [14:0]                   s1_a;
  logic [20:0]                   s1_x;
  logic [des_pkg::WEIGHT_W-1:0]  s1_w;
  des_pkg::tag_t                 s1_tag;

  logic                          s2_valid;
  logic                          s2_neg;
  logic                          s2_big;
  logic [31:0]                   s2_pa;
  logic [52:0]                   s2_px;
  logic [des_pkg::WEIGHT_W-1:0]  s2_w;
  des_pkg::tag_t                 s2_tag;

  logic                          neg;
  logic [63:0]                   mag;
  logic [32:0]                   q;
  logic [33:0]                   up;
  logic [des_pkg::SCORE_W-1:0]   urg;
  logic [31:0]                   tot;

  always_comb begin
    neg = in_sum < {1'b0, in_now};
    mag = neg ? ({1'b0, in_now} - in_sum) : (in_sum - {1'b0, in_now});
  end

  always_comb begin
    q = {1'b0, s2_pa} + {15'd0, s2_px[52:35]};
    up = {1'b0, q} + {24'd0, des_pkg::URG_BASE};
    if (s2_neg) begin
      if (s2_big || up > {3'd0, des_pkg::SCORE_MAX}) begin
        urg = des_pkg::SCORE_MAX;
      end else begin
        urg = up[des_pkg::SCORE_W-1:0];
      end
    end else begin
      if (s2_big || q >= {23'd0, des_pkg::URG_BASE}) begin
        urg = '0;
      end else begin
        urg = {21'd0, des_pkg::URG_BASE - q[9:0]};
      end
    end
    tot = {1'b0, urg} + {16'd0, s2_w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      out_valid <= s2_valid;
    end
    s1_neg <= neg;
    s1_big <= |mag[63:35];
    s1_a <= mag[34:20];
    s1_x <= {3'd0, mag[34:20], 3'd0} - {5'd0, mag[34:20], 1'b0} + {1'b0, mag[19:0]};
    s1_w <= in_weight;
    s1_tag <= in_tag;

    s2_neg <= s1_neg;
    s2_big <= s1_big;
    s2_pa <= {2'd0, s1_a} * {15'd0, RECIP_HI};
    s2_px <= {32'd0, s1_x} * {21'd0, RECIP_10};
    s2_w <= s1_w;
    s2_tag <= s1_tag;

    out_score <= tot[31] ? des_pkg::SCORE_MAX : tot[des_pkg::SCORE_W-1:0];
    out_tag <= s2_tag;
  end

endmodule

FILE: tb/sv/tb_deadline_eviction_selector_core.sv
// Self-checking testbench for deadline_eviction_selector_core: register/unregister/evict/count.
`timescale 1ns / 1ps
module tb_deadline_eviction_selector_core;

  localparam int CYCLE_LIMIT = 20000000;
  localparam logic [64:0] SAT31 = 65'h7FFFFFFF;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] key;
    logic [31:0] size;
    logic [30:0] score;
    logic [6:0]  tally;
    logic        last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [des_pkg::IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [des_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we;
  logic [des_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [des_pkg::WEIGHT_W-1:0] cfg_data;

  // shadow of the slot table
  logic        tbl_valid [des_pkg::DEPTH];
  logic [63:0] tbl_key   [des_pkg::DEPTH];
  logic [63:0] tbl_sum   [des_pkg::DEPTH];
  logic [1:0]  tbl_prio  [des_pkg::DEPTH];
  logic [31:0] tbl_size  [des_pkg::DEPTH];
  logic [31:0] tbl_order [des_pkg::DEPTH];
  logic [31:0] order_ctr;
  logic [15:0] w_cold, w_warm;

  outcome_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  logic [62:0] now_base = 63'd0;
  logic [63:0] key_pool [24];

  always #1 clk = ~clk;

  deadline_eviction_selector_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [30:0] urgency_score(int i, logic [62:0] now);
    logic [64:0] sum;
    logic [64:0] q;
    logic [64:0] u;
    logic [64:0] s;
    sum = {1'b0, tbl_sum[i]};
    if (sum >= {2'b0, now}) begin
      q = (sum - {2'b0, now}) / 10;
      u = (q < 1000) ? 65'd1000 - q : 65'd0;
    end else begin
      q = ({2'b0, now} - sum) / 10;
      u = 65'd1000 + q;
      if (u > SAT31) u = SAT31;
    end
    s = u + ((tbl_prio[i] == 2'd0) ? {49'd0, w_cold} : {49'd0, w_warm});
    if (s > SAT31) s = SAT31;
    return s[30:0];
  endfunction

  function automatic outcome_t mk(logic [2:0] st, logic [6:0] t);
    outcome_t o;
    o.status = st; o.key = '0; o.size = '0; o.score = '0; o.tally = t; o.last = 1'b1;
    return o;
  endfunction

  task automatic predict_op(logic [1:0] op, logic [63:0] key, logic [62:0] dl,
                            logic [2:0] pr, logic [31:0] sz, logic [62:0] now,
                            logic [6:0] lim);
    int hit;
    int fr;
    int best;
    int n;
    logic [30:0] bs;
    logic [30:0] sc;
    outcome_t o;
    hit = -1; fr = -1;
    for (int i = 0; i < des_pkg::DEPTH; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_valid[i] && fr < 0) fr = i;
    end
    case (op)
      des_pkg::OP_REG: begin
        if (pr > 3'd3 || sz == '0) pending_results.push_back(mk(des_pkg::ST_INVALID, '0));
        else if (hit >= 0) pending_results.push_back(mk(des_pkg::ST_EXISTS, '0));
        else if (fr < 0) pending_results.push_back(mk(des_pkg::ST_FULL, '0));
        else begin
          tbl_valid[fr] = 1'b1; tbl_key[fr] = key;
          tbl_sum[fr] = {1'b0, dl} + {1'b0, now};
          tbl_prio[fr] = pr[1:0]; tbl_size[fr] = sz;
          tbl_order[fr] = order_ctr; order_ctr++;
          pending_results.push_back(mk(des_pkg::ST_OK, '0));
        end
      end
      des_pkg::OP_UNREG: begin
        if (hit < 0) pending_results.push_back(mk(des_pkg::ST_NOTFOUND, '0));
        else begin
          tbl_valid[hit] = 1'b0;
          pending_results.push_back(mk(des_pkg::ST_OK, '0));
        end
      end
      des_pkg::OP_COUNT: begin
        n = 0;
        for (int i = 0; i < des_pkg::DEPTH; i++)
          if (tbl_valid[i] && tbl_prio[i] <= 2'd1) n++;
        if (n > 127) n = 127;
        pending_results.push_back(mk(des_pkg::ST_OK, n[6:0]));
      end
      default: begin
        n = (lim > des_pkg::MAX_SCAN) ? des_pkg::MAX_SCAN : lim;
        for (int d = 0; d < n; d++) begin
          best = -1; bs = '0;
          for (int i = 0; i < des_pkg::DEPTH; i++) begin
            if (tbl_valid[i] && tbl_prio[i] <= 2'd1) begin
              sc = urgency_score(i, now);
              if (best < 0 || sc > bs || (sc == bs && tbl_order[i] < tbl_order[best])) begin
                best = i; bs = sc;
              end
            end
          end
          if (best < 0) break;
          tbl_valid[best] = 1'b0;
          o.status = des_pkg::ST_OK; o.key = tbl_key[best]; o.size = tbl_size[best];
          o.score = bs; o.tally = 7'(d + 1); o.last = 1'b0;
          pending_results.push_back(o);
        end
        if (pending_results.size() == 0 || pending_results[$].last)
          pending_results.push_back(mk(des_pkg::ST_NONE, '0));
        else pending_results[$].last = 1'b1;
      end
    endcase
  endtask

  task automatic send_word(logic [1:0] op, logic [63:0] key, logic [62:0] dl,
                           logic [2:0] pr, logic [31:0] sz, logic [62:0] now,
                           logic [6:0] lim);
    if (!no_idle && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, lim, now, sz, pr, dl, key, op};
    do @(posedge clk); while (!s_tready);
    predict_op(op, key, dl, pr, sz, now, lim);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_weight(logic [des_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == des_pkg::REG_WEIGHT_COLD) w_cold = val; else w_warm = val;
  endtask

  task automatic test_register_checks;
    send_word(des_pkg::OP_REG, 64'h1, 63'd100, 3'd4, 32'd8, 63'd0, 7'd0);
    send_word(des_pkg::OP_REG, 64'h1, 63'd100, 3'd0, 32'd0, 63'd0, 7'd0);
    send_word(des_pkg::OP_REG, 64'h1, 63'd100, 3'd0, 32'd8, 63'd0, 7'd0);
    send_word(des_pkg::OP_REG, 64'h1, 63'd5, 3'd1, 32'd9, 63'd3, 7'd0);
    send_word(des_pkg::OP_REG, '1, '1, 3'd1, '1, 63'd10, 7'd0);
    send_word(des_pkg::OP_REG, 64'h2, 63'd100, 3'd2, 32'd1, 63'd10, 7'd0);
    send_word(des_pkg::OP_REG, 64'h3, 63'd100, 3'd3, 32'd1, 63'd10, 7'd0);
    send_word(des_pkg::OP_REG, 64'h4, 63'd0, 3'd0, 32'd7, 63'd0, 7'd0);
    send_word(des_pkg::OP_REG, 64'h5, 63'd90, 3'd0, 32'd7, 63'd10, 7'd0);
    send_word(des_pkg::OP_COUNT, '0, '0, '0, '0, 63'd10, 7'd0);
    send_word(des_pkg::OP_UNREG, 64'h2, '0, '0, '0, 63'd10, 7'd0);
    send_word(des_pkg::OP_UNREG, 64'h2, '0, '0, '0, 63'd10, 7'd0);
  endtask

  task automatic test_evict_cases;
    send_word(des_pkg::OP_EVICT, '0, '0, '0, '0, 63'd20, 7'd0);
    send_word(des_pkg::OP_EVICT, '0, '0, '0, '0, 63'd20, 7'd1);
    send_word(des_pkg::OP_EVICT, '0, '0, '0, '0, '1, 7'd127);
    send_word(des_pkg::OP_EVICT, '0, '0, '0, '0, '1, 7'd2);
    send_word(des_pkg::OP_COUNT, '0, '0, '0, '0, 63'd0, 7'd0);
    send_word(des_pkg::OP_UNREG, 64'h3, '0, '0, '0, 63'd0, 7'd0);
  endtask

  task automatic test_table_full;
    for (int i = 0; i < des_pkg::DEPTH + 1; i++)
      send_word(des_pkg::OP_REG, {$urandom, $urandom}, 63'($urandom_range(3000)),
                3'($urandom_range(1)), 32'($urandom_range(1, 99)), 63'd50, 7'd0);
    send_word(des_pkg::OP_COUNT, '0, '0, '0, '0, 63'd60, 7'd0);
    send_word(des_pkg::OP_EVICT, '0, '0, '0, '0, 63'd60, 7'd64);
  endtask

  task automatic test_random(int n_words);
    logic [1:0] op;
    logic [63:0] key;
    logic [62:0] dl;
    logic [62:0] now;
    logic [31:0] sz;
    logic [2:0] pr;
    logic [6:0] lim;
    int r;
    for (int k = 0; k < n_words; k++) begin
      no_idle = (k >= n_words / 3) && (k < n_words / 2);
      now_base += 63'($urandom_range(0, 60));
      r = $urandom_range(99);
      op = (r < 45) ? des_pkg::OP_REG : (r < 65) ? des_pkg::OP_UNREG :
           (r < 80) ? des_pkg::OP_EVICT : des_pkg::OP_COUNT;
      key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(23)];
      dl = ($urandom_range(9) == 0) ? 63'({$urandom, $urandom}) : 63'($urandom_range(20000));
      now = ($urandom_range(19) == 0) ? 63'({$urandom, $urandom}) : now_base;
      pr = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
      sz = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      lim = ($urandom_range(14) == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(4));
      send_word(op, key, dl, pr, sz, now, lim);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[2:0] !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, m_tdata[2:0]); errors++;
        end
        if (m_tdata[66:3] !== e.key) begin
          $display("%0t: key exp %h got %h", $time, e.key, m_tdata[66:3]); errors++;
        end
        if (m_tdata[98:67] !== e.size) begin
          $display("%0t: size exp %h got %h", $time, e.size, m_tdata[98:67]); errors++;
        end
        if (m_tdata[129:99] !== e.score) begin
          $display("%0t: score exp %0d got %0d", $time, e.score, m_tdata[129:99]); errors++;
        end
        if (m_tdata[136:130] !== e.tally) begin
          $display("%0t: tally exp %0d got %0d", $time, e.tally, m_tdata[136:130]); errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last exp %b got %b", $time, e.last, m_tlast); errors++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int i = 0; i < des_pkg::DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    order_ctr = '0;
    w_cold = 16'd1000;
    w_warm = 16'd500;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_checks();
    test_evict_cases();
    write_weight(des_pkg::REG_WEIGHT_COLD, 16'd0);
    write_weight(des_pkg::REG_WEIGHT_WARM, 16'hFFFF);
    test_table_full();
    test_random(100);
    write_weight(des_pkg::REG_WEIGHT_COLD, 16'hFFFF);
    write_weight(des_pkg::REG_WEIGHT_WARM, 16'd0);
    test_random(100);
    write_weight(des_pkg::REG_WEIGHT_COLD, 16'd1000);
    write_weight(des_pkg::REG_WEIGHT_WARM, 16'd500);
    test_random(120);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/des_pkg.sv
sv/des_slot_mem.sv
sv/des_score_unit.sv
sv/deadline_eviction_selector_core.sv
tb/sv/tb_deadline_eviction_selector_core.sv
